// File: rtl/bfts_pkg.sv
// Shared types, opcodes and length tables for the bytecode function-table scanner.
// Used by bfts_cell and bytecode_function_table_scanner_unit; depends on nothing.
`default_nettype none

package bfts_pkg;

    localparam int DEF_NEST_DEPTH = 16;
    localparam int DEF_ADDR_BITS  = 32;
    localparam int DEF_INDEX_BITS = 16;

    localparam int ARGS_W  = 16;
    localparam int COUNT_W = 17;
    localparam int SKIP_W  = 4;

    localparam logic [7:0] OP_TYPED = 8'h01;
    localparam logic [7:0] OP_FN    = 8'h05;
    localparam logic [7:0] OP_ARG   = 8'h06;
    localparam logic [7:0] OP_END   = 8'h19;

    localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(65536);

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } t_state;

    // stack shift control handed to every cell
    typedef struct packed {
        logic push;
        logic pop;
        logic inc;
    } t_cell_op;

    // payload size that follows a typed-load type byte
    function automatic logic [SKIP_W-1:0] type_size(input logic [7:0] t);
        logic [SKIP_W-1:0] r;
        begin
            case (t) inside
                8'h01, 8'h03, 8'h09: r = SKIP_W'(4);
                8'h02, 8'h04:        r = SKIP_W'(8);
                8'h05, 8'h07:        r = SKIP_W'(1);
                8'h08:               r = SKIP_W'(2);
                default:             r = '0;
            endcase
            return r;
        end
    endfunction

    // bytes following the opcode byte
    function automatic logic [SKIP_W-1:0] op_tail(input logic [7:0] op);
        logic [SKIP_W-1:0] r;
        begin
            case (op) inside
                8'h02, 8'h03, [8'h1D:8'h20]:                      r = SKIP_W'(6);
                8'h05, 8'h06, 8'h16, 8'h1A, 8'h1B:                r = SKIP_W'(4);
                8'h04, [8'h0E:8'h15], 8'h18, 8'h1C, [8'h21:8'h2C]: r = SKIP_W'(1);
                default:                                          r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/bfts_cell.sv
// One entry of the open-function stack: start, index and argument count.
// Shifts toward its neighbors on push/pop; uses bfts_pkg.
`default_nettype none

module bfts_cell #(
    parameter int ADDR_BITS  = bfts_pkg::DEF_ADDR_BITS,
    parameter int INDEX_BITS = bfts_pkg::DEF_INDEX_BITS
) (
    input  wire                           i_clk,
    input  bfts_pkg::t_cell_op            i_op,
    input  wire  [ADDR_BITS-1:0]          i_left_start,
    input  wire  [INDEX_BITS-1:0]         i_left_index,
    input  wire  [bfts_pkg::ARGS_W-1:0]   i_left_args,
    input  wire  [ADDR_BITS-1:0]          i_right_start,
    input  wire  [INDEX_BITS-1:0]         i_right_index,
    input  wire  [bfts_pkg::ARGS_W-1:0]   i_right_args,
    output logic [ADDR_BITS-1:0]          o_start,
    output logic [INDEX_BITS-1:0]         o_index,
    output logic [bfts_pkg::ARGS_W-1:0]   o_args
);
    import bfts_pkg::*;

    logic [ADDR_BITS-1:0]  r_start;
    logic [INDEX_BITS-1:0] r_index;
    logic [ARGS_W-1:0]     r_args;

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_start <= i_left_start;
            r_index <= i_left_index;
            r_args  <= i_left_args;
        end else if (i_op.pop) begin
            r_start <= i_right_start;
            r_index <= i_right_index;
            r_args  <= i_right_args;
        end else if (i_op.inc && (r_args != '1)) begin
            r_args <= r_args + ARGS_W'(1);
        end
    end

    assign o_start = r_start;
    assign o_index = r_index;
    assign o_args  = r_args;

endmodule

`default_nettype wire

// File: rtl/bytecode_function_table_scanner_unit.sv
// Bytecode function-table scanner: decoder, control and a chain of stack cells.
// A closing 0x19 has its record loaded into the output register as the byte is accepted.
// Throughput: one byte per cycle while results drain; after the final byte of a program
// input stalls while the flush emits one record per open function, then the summary.
// Synchronous active-low reset clears control state; stack cells hold no reset.
// Depends on bfts_pkg and bfts_cell.
`default_nettype none

module bytecode_function_table_scanner_unit #(
    parameter int NEST_DEPTH = bfts_pkg::DEF_NEST_DEPTH,
    parameter int ADDR_BITS  = bfts_pkg::DEF_ADDR_BITS,
    parameter int INDEX_BITS = bfts_pkg::DEF_INDEX_BITS
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // slave side: one bytecode byte per transaction
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // code_byte
    input  wire          s_axis_tlast,   // last_byte
    // master side: one result per transaction
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // [15:0] func_index, [47:16] start_addr, [79:48] end_addr, [95:80] arg_count,
    // [96] closed, [97] depth_overflow, [114:98] function_count, [119:115] zero
    output logic [119:0] m_axis_tdata,
    output logic         m_axis_tuser,   // kind
    output logic         m_axis_tlast    // last_result
);
    import bfts_pkg::*;

    localparam int DEPTH_W = $clog2(NEST_DEPTH + 1);

    // control state
    t_state               r_state, n_state;
    logic [ADDR_BITS-1:0] r_pos, n_pos;
    logic [SKIP_W-1:0]    r_skip, n_skip;
    logic                 r_await, n_await;
    logic [DEPTH_W-1:0]   r_depth, n_depth;
    logic [COUNT_W-1:0]   r_funcs, n_funcs;
    logic                 r_ovf, n_ovf;

    // output register
    logic                 r_out_valid;
    logic                 r_out_kind, n_out_kind;
    logic [15:0]          r_out_idx, n_out_idx;
    logic [31:0]          r_out_start, n_out_start;
    logic [31:0]          r_out_end, n_out_end;
    logic [ARGS_W-1:0]    r_out_args, n_out_args;
    logic                 r_out_closed, n_out_closed;
    logic                 r_out_ovf, n_out_ovf;
    logic [COUNT_W-1:0]   r_out_cnt, n_out_cnt;
    logic                 r_out_last, n_out_last;
    logic                 n_out_load;

    logic                 w_advance;
    logic                 w_accept;
    t_cell_op             w_op;
    logic [ADDR_BITS-1:0] w_new_start;
    logic [INDEX_BITS-1:0] w_new_index;

    // stack chain, cell 0 is the innermost open function
    logic [ADDR_BITS-1:0]  w_start [NEST_DEPTH];
    logic [INDEX_BITS-1:0] w_index [NEST_DEPTH];
    logic [ARGS_W-1:0]     w_args  [NEST_DEPTH];

    // output register frees up when empty or taken this cycle
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_advance && (r_state == ST_RUN);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // new stack entry on FN: start just past the 4-byte identifier
    assign w_new_start = r_pos + ADDR_BITS'(5);
    assign w_new_index = INDEX_BITS'(r_funcs);

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_skip       = r_skip;
        n_await      = r_await;
        n_depth      = r_depth;
        n_funcs      = r_funcs;
        n_ovf        = r_ovf;
        w_op         = '0;
        n_out_load   = 1'b0;
        n_out_kind   = 1'b0;
        n_out_idx    = 16'(w_index[0]);
        n_out_start  = 32'(w_start[0]);
        n_out_end    = '0;
        n_out_args   = w_args[0];
        n_out_closed = 1'b0;
        n_out_ovf    = 1'b0;
        n_out_cnt    = '0;
        n_out_last   = 1'b0;

        case (r_state)
            ST_RUN: begin
                if (w_accept) begin
                    if (r_skip != '0) begin
                        n_skip = r_skip - SKIP_W'(1);
                    end else if (r_await) begin
                        n_await = 1'b0;
                        n_skip  = type_size(s_axis_tdata);
                    end else if (s_axis_tdata == OP_FN) begin
                        if (r_funcs != COUNT_SAT) begin
                            n_funcs = r_funcs + COUNT_W'(1);
                        end
                        if (r_depth < DEPTH_W'(NEST_DEPTH)) begin
                            w_op.push = 1'b1;
                            n_depth   = r_depth + DEPTH_W'(1);
                        end else begin
                            // no room: counted and indexed, never recorded
                            n_ovf = 1'b1;
                        end
                        n_skip = op_tail(s_axis_tdata);
                    end else if ((s_axis_tdata == OP_END) && (r_depth != '0)) begin
                        // close innermost: emit record, pop
                        w_op.pop     = 1'b1;
                        n_depth      = r_depth - DEPTH_W'(1);
                        n_out_load   = 1'b1;
                        n_out_end    = 32'(r_pos);
                        n_out_closed = 1'b1;
                        n_out_last   = !s_axis_tlast;
                    end else if (s_axis_tdata == OP_TYPED) begin
                        n_await = 1'b1;
                    end else begin
                        if ((s_axis_tdata == OP_ARG) && (r_depth != '0)) begin
                            w_op.inc = 1'b1;
                        end
                        // unknown opcodes fall through with no tail
                        n_skip = op_tail(s_axis_tdata);
                    end
                    n_pos = r_pos + ADDR_BITS'(1);
                    if (s_axis_tlast) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (w_advance) begin
                    n_out_load = 1'b1;
                    if (r_depth != '0) begin
                        // unclosed function, end address 0
                        w_op.pop = 1'b1;
                        n_depth  = r_depth - DEPTH_W'(1);
                    end else begin
                        n_out_kind  = 1'b1;
                        n_out_idx   = '0;
                        n_out_start = '0;
                        n_out_args  = '0;
                        n_out_ovf   = r_ovf;
                        n_out_cnt   = r_funcs;
                        n_out_last  = 1'b1;
                        // start over for the next program
                        n_state = ST_RUN;
                        n_pos   = '0;
                        n_skip  = '0;
                        n_await = 1'b0;
                        n_funcs = '0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_pos       <= '0;
            r_skip      <= '0;
            r_await     <= 1'b0;
            r_depth     <= '0;
            r_funcs     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_skip  <= n_skip;
            r_await <= n_await;
            r_depth <= n_depth;
            r_funcs <= n_funcs;
            r_ovf   <= n_ovf;
            if (w_advance) begin
                r_out_valid <= n_out_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && n_out_load) begin
            r_out_kind   <= n_out_kind;
            r_out_idx    <= n_out_idx;
            r_out_start  <= n_out_start;
            r_out_end    <= n_out_end;
            r_out_args   <= n_out_args;
            r_out_closed <= n_out_closed;
            r_out_ovf    <= n_out_ovf;
            r_out_cnt    <= n_out_cnt;
            r_out_last   <= n_out_last;
        end
    end

    // chain of stack cells; push moves toward the far end, pop toward cell 0
    generate
        for (genvar k = 0; k < NEST_DEPTH; k++) begin : g_cell
            t_cell_op              w_cop;
            logic [ADDR_BITS-1:0]  w_ls, w_rs;
            logic [INDEX_BITS-1:0] w_li, w_ri;
            logic [ARGS_W-1:0]     w_la, w_ra;

            assign w_cop.push = w_op.push;
            assign w_cop.pop  = w_op.pop;
            assign w_cop.inc  = (k == 0) ? w_op.inc : 1'b0;

            if (k == 0) begin : g_head
                assign w_ls = w_new_start;
                assign w_li = w_new_index;
                assign w_la = '0;
            end else begin : g_body
                assign w_ls = w_start[k-1];
                assign w_li = w_index[k-1];
                assign w_la = w_args[k-1];
            end

            if (k == NEST_DEPTH - 1) begin : g_tail
                assign w_rs = '0;
                assign w_ri = '0;
                assign w_ra = '0;
            end else begin : g_link
                assign w_rs = w_start[k+1];
                assign w_ri = w_index[k+1];
                assign w_ra = w_args[k+1];
            end

            bfts_cell #(
                .ADDR_BITS  (ADDR_BITS),
                .INDEX_BITS (INDEX_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_op          (w_cop),
                .i_left_start  (w_ls),
                .i_left_index  (w_li),
                .i_left_args   (w_la),
                .i_right_start (w_rs),
                .i_right_index (w_ri),
                .i_right_args  (w_ra),
                .o_start       (w_start[k]),
                .o_index       (w_index[k]),
                .o_args        (w_args[k])
            );
        end
    endgenerate

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {5'b0, r_out_cnt, r_out_ovf, r_out_closed, r_out_args,
                            r_out_end, r_out_start, r_out_idx};

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking bench for bytecode_function_table_scanner_unit: byte stream in, function records out.
// Depends on bfts_pkg (opcodes, saturation constant) and the scanner RTL; needs no other files.
`timescale 1ns / 1ps

module tb;
    import bfts_pkg::*;

    localparam int NEST       = DEF_NEST_DEPTH;
    localparam int RAND_BYTES = 275;
    localparam int DIR_N      = 24;
    localparam int IDLE_PCT   = 37;

    // opcode groups by instruction length
    localparam logic [7:0] OP_NOP     = 8'h00;
    localparam logic [7:0] OP_W7_A    = 8'h02;
    localparam logic [7:0] OP_W7_B    = 8'h03;
    localparam logic [7:0] OP_W7_LO   = 8'h1D;
    localparam logic [7:0] OP_W7_HI   = 8'h20;
    localparam logic [7:0] OP_W5_A    = 8'h16;
    localparam logic [7:0] OP_W5_B    = 8'h1A;
    localparam logic [7:0] OP_W5_C    = 8'h1B;
    localparam logic [7:0] OP_W2_A    = 8'h04;
    localparam logic [7:0] OP_W2_LO   = 8'h0E;
    localparam logic [7:0] OP_W2_HI   = 8'h15;
    localparam logic [7:0] OP_W2_B    = 8'h18;
    localparam logic [7:0] OP_W2_C    = 8'h1C;
    localparam logic [7:0] OP_W2_LO2  = 8'h21;
    localparam logic [7:0] OP_W2_HI2  = 8'h2C;
    localparam logic [7:0] OP_UNDEF   = 8'h0B;   // not in any length group
    localparam logic [7:0] OP_ALL_ONE = 8'hFF;

    // type bytes of the typed opcode, by payload size
    localparam logic [7:0] TY_4B_A = 8'h01;
    localparam logic [7:0] TY_8B_A = 8'h02;
    localparam logic [7:0] TY_4B_B = 8'h03;
    localparam logic [7:0] TY_8B_B = 8'h04;
    localparam logic [7:0] TY_1B_A = 8'h05;
    localparam logic [7:0] TY_1B_B = 8'h07;
    localparam logic [7:0] TY_2B   = 8'h08;
    localparam logic [7:0] TY_4B_C = 8'h09;
    localparam logic [7:0] TY_MAX  = 8'h0A;

    typedef struct packed {
        logic        kind;
        logic [15:0] func_index;
        logic [31:0] start_addr;
        logic [31:0] end_addr;
        logic [15:0] arg_count;
        logic        closed;
        logic        depth_overflow;
        logic [16:0] function_count;
        logic        last_result;
    } t_scan_rec;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       typed;   // want holds the hand-written result
        t_scan_rec  want;
    } t_dir_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;        // code_byte
    logic         s_axis_tlast = 1'b0;      // last_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // func_index, start_addr, end_addr, arg_count, closed, depth_overflow, function_count
    logic [119:0] m_axis_tdata;
    logic         m_axis_tuser;             // kind
    logic         m_axis_tlast;             // last_result

    bytecode_function_table_scanner_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scanner mirror: decode position, skip counter and function stack
    // ------------------------------------------------------------------
    logic [31:0] pc;
    logic [3:0]  skip_cnt;
    logic        want_type;
    logic [4:0]  depth;
    logic [31:0] stk_start [NEST];
    logic [15:0] stk_idx   [NEST];
    logic [15:0] stk_args  [NEST];
    logic [16:0] fn_total;
    logic        ovf_flag;

    t_scan_rec   want_q [$];   // records still owed by the DUT
    t_dir_row    feed_q [$];   // byte on the bus, waiting for its transaction
    int          err_cnt = 0;
    logic        in_taken = 1'b0;
    logic        calm = 1'b0;  // both sides run without idling

    function automatic logic [3:0] typed_len(input logic [7:0] t);
        case (t)
            TY_4B_A, TY_4B_B, TY_4B_C: return 4'd4;
            TY_8B_A, TY_8B_B:          return 4'd8;
            TY_1B_A, TY_1B_B:          return 4'd1;
            TY_2B:                     return 4'd2;
            default:                   return 4'd0;
        endcase
    endfunction

    // bytes after the opcode byte
    function automatic logic [3:0] body_len(input logic [7:0] op);
        if (op == OP_W7_A || op == OP_W7_B || (op >= OP_W7_LO && op <= OP_W7_HI))
            return 4'd6;
        if (op == OP_FN || op == OP_ARG || op == OP_W5_A || op == OP_W5_B || op == OP_W5_C)
            return 4'd4;
        if (op == OP_W2_A || (op >= OP_W2_LO && op <= OP_W2_HI) || op == OP_W2_B ||
            op == OP_W2_C || (op >= OP_W2_LO2 && op <= OP_W2_HI2))
            return 4'd1;
        return 4'd0;
    endfunction

    function automatic void clear_scan();
        pc        = '0;
        skip_cnt  = '0;
        want_type = 1'b0;
        depth     = '0;
        fn_total  = '0;
        ovf_flag  = 1'b0;
    endfunction

    function automatic t_scan_rec summary_rec(input logic ovf, input logic [16:0] cnt);
        t_scan_rec r;
        r = '0;
        r.kind           = 1'b1;
        r.depth_overflow = ovf;
        r.function_count = cnt;
        r.last_result    = 1'b1;
        return r;
    endfunction

    // advance the mirror by one byte; res gets the records it causes, in order
    function automatic void scan_byte(input logic [7:0] b, input logic last,
                                      output t_scan_rec res [$]);
        t_scan_rec r;
        res = {};
        if (skip_cnt != 0) begin
            skip_cnt = skip_cnt - 1'b1;
        end else if (want_type) begin
            want_type = 1'b0;
            skip_cnt  = typed_len(b);
        end else if (b == OP_FN) begin
            if (depth < NEST) begin
                stk_start[depth] = pc + 32'd5;
                stk_idx[depth]   = fn_total[15:0];
                stk_args[depth]  = '0;
                depth = depth + 1'b1;
            end else begin
                ovf_flag = 1'b1;   // counted and indexed, never recorded
            end
            if (fn_total != COUNT_SAT)
                fn_total = fn_total + 1'b1;
            skip_cnt = 4'd4;
        end else if (b == OP_END && depth != 0) begin
            depth = depth - 1'b1;
            r = '0;
            r.func_index = stk_idx[depth];
            r.start_addr = stk_start[depth];
            r.end_addr   = pc;
            r.arg_count  = stk_args[depth];
            r.closed     = 1'b1;
            res = {res, r};
        end else if (b == OP_TYPED) begin
            want_type = 1'b1;
        end else begin
            // arg at depth zero is a plain 5-byte instruction
            if (b == OP_ARG && depth != 0 && stk_args[depth - 1] != 16'hFFFF)
                stk_args[depth - 1] = stk_args[depth - 1] + 1'b1;
            skip_cnt = body_len(b);
        end
        pc = pc + 1'b1;

        if (last) begin
            // unclosed functions drain innermost first, end address zero
            while (depth != 0) begin
                depth = depth - 1'b1;
                r = '0;
                r.func_index = stk_idx[depth];
                r.start_addr = stk_start[depth];
                r.arg_count  = stk_args[depth];
                res = {res, r};
            end
            res = {res, summary_rec(ovf_flag, fn_total)};
            clear_scan();
        end
        if (res.size() != 0)
            res[res.size() - 1].last_result = 1'b1;
    endfunction

    function automatic void cmp(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: both transactions sampled on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_scan_rec res [$];
        t_scan_rec w;
        t_dir_row  note;
        if (!i_rst_n) begin
            clear_scan();
            in_taken = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (want_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    err_cnt++;
                end else begin
                    w = want_q.pop_front();
                    cmp("kind",           32'(w.kind),           32'(m_axis_tuser));
                    cmp("func_index",     32'(w.func_index),     32'(m_axis_tdata[15:0]));
                    cmp("start_addr",     w.start_addr,          m_axis_tdata[47:16]);
                    cmp("end_addr",       w.end_addr,            m_axis_tdata[79:48]);
                    cmp("arg_count",      32'(w.arg_count),      32'(m_axis_tdata[95:80]));
                    cmp("closed",         32'(w.closed),         32'(m_axis_tdata[96]));
                    cmp("depth_overflow", 32'(w.depth_overflow), 32'(m_axis_tdata[97]));
                    cmp("function_count", 32'(w.function_count), 32'(m_axis_tdata[114:98]));
                    cmp("last_result",    32'(w.last_result),    32'(m_axis_tlast));
                end
            end
            in_taken = s_axis_tvalid && s_axis_tready;
            if (in_taken) begin
                note = feed_q.pop_front();
                scan_byte(s_axis_tdata, s_axis_tlast, res);
                // hand-written rows replace the mirror's single record
                if (note.typed)
                    want_q = {want_q, note.want};
                else
                    want_q = {want_q, res};
            end
        end
    end

    // result side back-pressure, updated on the falling edge
    always @(negedge i_clk)
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);

    // ------------------------------------------------------------------
    // Byte sender; every call starts and ends on a falling edge
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] code, input logic last,
                             input logic typed, input t_scan_rec want);
        t_dir_row row;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        row    = '{code, last, typed, want};
        feed_q = {feed_q, row};
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tlast  <= last;
        do @(negedge i_clk); while (!in_taken);
    endtask

    // hold off the sender until every owed record is out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (want_q.size() != 0 || feed_q.size() != 0);
    endtask

    task automatic push_instr(ref logic [7:0] prog [$], input logic [7:0] op,
                              input int tail);
        prog = {prog, op};
        repeat (tail) prog = {prog, 8'($urandom)};
    endtask

    // one program: mostly well-formed nesting, some deep overflow, some noise
    task automatic build_program(ref logic [7:0] prog [$], input logic force_deep);
        int         pick;
        int         nest;
        logic [7:0] op;
        prog = {};
        pick = $urandom_range(99);
        if (force_deep || pick < 7) begin
            // more FN than the stack holds, then a few closes, rest flushed
            repeat ($urandom_range(NEST + 1, NEST + 3)) begin
                push_instr(prog, OP_FN, 4);
                if ($urandom_range(2) == 0)
                    push_instr(prog, OP_ARG, 4);
            end
            repeat ($urandom_range(0, 4)) prog = {prog, OP_END};
            prog = {prog, OP_NOP};
        end else if (pick < 20) begin
            repeat ($urandom_range(1, 24)) prog = {prog, 8'($urandom)};
        end else begin
            nest = 0;
            repeat ($urandom_range(2, 12)) begin
                pick = $urandom_range(99);
                if (pick < 28) begin
                    push_instr(prog, OP_FN, 4);
                    nest++;
                end else if (pick < 48) begin
                    prog = {prog, OP_END};
                    if (nest != 0)
                        nest--;
                end else if (pick < 63) begin
                    push_instr(prog, OP_ARG, 4);
                end else if (pick < 75) begin
                    op = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(0, TY_MAX));
                    prog = {prog, OP_TYPED};
                    push_instr(prog, op, typed_len(op));
                end else begin
                    do
                        op = 8'($urandom_range(0, OP_W2_HI2));
                    while (op == OP_TYPED || op == OP_FN || op == OP_ARG || op == OP_END);
                    push_instr(prog, op, body_len(op));
                end
            end
            if ($urandom_range(1) == 1)
                repeat (nest) prog = {prog, OP_END};
            // broken tail: trailing bytes dropped at random, the first byte always kept
            if ($urandom_range(4) == 0 && prog.size() > 1)
                repeat ($urandom_range(1, prog.size() - 1)) void'(prog.pop_back());
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    t_dir_row dir_tab [DIR_N];

    initial begin
        t_scan_rec  close_rec;
        logic [7:0] prog [$];
        int         rand_sent;
        int         prog_no;

        close_rec = '0;
        close_rec.start_addr  = 32'd5;
        close_rec.end_addr    = 32'd13;
        close_rec.arg_count   = 16'd1;
        close_rec.closed      = 1'b1;
        close_rec.last_result = 1'b1;

        // one-byte programs: empty summary, close and arg at depth zero
        dir_tab[0]  = '{OP_NOP,     1'b1, 1'b1, summary_rec(1'b0, 17'd0)};
        dir_tab[1]  = '{OP_END,     1'b1, 1'b1, summary_rec(1'b0, 17'd0)};
        dir_tab[2]  = '{OP_ARG,     1'b1, 1'b1, summary_rec(1'b0, 17'd0)};
        // FN, one arg, typed load whose payload hides a close, then the close
        dir_tab[3]  = '{OP_FN,      1'b0, 1'b0, '0};
        dir_tab[4]  = '{OP_ALL_ONE, 1'b0, 1'b0, '0};
        dir_tab[5]  = '{OP_NOP,     1'b0, 1'b0, '0};
        dir_tab[6]  = '{8'hAA,      1'b0, 1'b0, '0};
        dir_tab[7]  = '{8'h55,      1'b0, 1'b0, '0};
        dir_tab[8]  = '{OP_ARG,     1'b0, 1'b0, '0};
        dir_tab[9]  = '{OP_END,     1'b0, 1'b0, '0};
        dir_tab[10] = '{OP_FN,      1'b0, 1'b0, '0};
        dir_tab[11] = '{OP_ARG,     1'b0, 1'b0, '0};
        dir_tab[12] = '{8'h80,      1'b0, 1'b0, '0};
        dir_tab[13] = '{OP_TYPED,   1'b0, 1'b0, '0};
        dir_tab[14] = '{TY_1B_A,    1'b0, 1'b0, '0};
        dir_tab[15] = '{OP_END,     1'b0, 1'b0, '0};
        dir_tab[16] = '{OP_END,     1'b0, 1'b1, close_rec};
        // unknown opcode as the final byte
        dir_tab[17] = '{OP_UNDEF,   1'b1, 1'b1, summary_rec(1'b0, 17'd1)};
        // nested FN cut off by the final byte: two flushed records + summary
        dir_tab[18] = '{OP_FN,      1'b0, 1'b0, '0};
        dir_tab[19] = '{8'h7F,      1'b0, 1'b0, '0};
        dir_tab[20] = '{8'h80,      1'b0, 1'b0, '0};
        dir_tab[21] = '{8'h01,      1'b0, 1'b0, '0};
        dir_tab[22] = '{8'hFE,      1'b0, 1'b0, '0};
        dir_tab[23] = '{OP_FN,      1'b1, 1'b0, '0};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[k])
            send_byte(dir_tab[k].code, dir_tab[k].last, dir_tab[k].typed, dir_tab[k].want);
        drain();

        rand_sent = 0;
        prog_no   = 0;
        while (rand_sent < RAND_BYTES) begin
            build_program(prog, prog_no == 1);
            calm = (rand_sent >= 120 && rand_sent < 200);
            foreach (prog[k])
                send_byte(prog[k], k == prog.size() - 1, 1'b0, '0);
            rand_sent += prog.size();
            if (prog_no == 4)
                drain();
            prog_no++;
        end
        calm = 1'b0;

        drain();
        // keep the clock running to catch stray records
        repeat (NEST + 8) @(negedge i_clk);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
